// File: design/sdspi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// SD SPI host engine package
// Shared payload types, action codes, phase codes and protocol constants.
// ---------------------------------------------------------------------------
package sdspi_pkg;

    localparam int BLOCK_BYTES = 512;
    localparam int BC_W        = 16;

    typedef enum logic [1:0] {
        ACT_INIT  = 2'd0,
        ACT_READ  = 2'd1,
        ACT_WRITE = 2'd2,
        ACT_BYTE  = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        CFG_SD2_RETRIES = 3'd0,
        CFG_LEG_RETRIES = 3'd1,
        CFG_RESP_POLLS  = 3'd2,
        CFG_TOKEN_WAIT  = 3'd3,
        CFG_WAKE_BYTES  = 3'd4
    } t_cfg_index;

    typedef enum logic [4:0] {
        PH_IDLE, PH_WAKE, PH_CMD0, PH_GAP0, PH_CMD8, PH_OCR8, PH_V2LOOP,
        PH_CMD58, PH_OCR58, PH_PROBE, PH_LEGLOOP, PH_CMD16, PH_RD_CMD,
        PH_RD_GAP, PH_RD_TOKEN, PH_RD_DATA, PH_RD_TAIL, PH_WR_CMD, PH_WR_GAP,
        PH_WR_TOKEN, PH_WR_DATA, PH_WR_TAIL, PH_WR_RESP, PH_WR_BUSY
    } t_phase;

    localparam logic [7:0] OP_IDLE        = 8'h40;
    localparam logic [7:0] OP_SEND_OP     = 8'h41;
    localparam logic [7:0] OP_IF_COND     = 8'h48;
    localparam logic [7:0] OP_SET_LEN     = 8'h50;
    localparam logic [7:0] OP_READ        = 8'h51;
    localparam logic [7:0] OP_WRITE       = 8'h58;
    localparam logic [7:0] OP_APP         = 8'h77;
    localparam logic [7:0] OP_READ_OCR    = 8'h7A;
    localparam logic [7:0] OP_APP_OP_COND = 8'hE9;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_IDLE  = 2'd1;
    localparam logic [1:0] ST_RD_FAIL  = 2'd2;
    localparam logic [1:0] ST_WR_FAIL  = 2'd3;

    localparam logic [2:0] CK_UNKNOWN  = 3'd0;
    localparam logic [2:0] CK_MMC      = 3'd1;
    localparam logic [2:0] CK_SD1      = 3'd2;
    localparam logic [2:0] CK_SD2_BYTE = 3'd3;
    localparam logic [2:0] CK_SD2_BLK  = 3'd4;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] block_address;
        logic [7:0]  rx_byte;
        logic [7:0]  write_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       exchange;
        logic       select_card;
        logic       slow_clock;
        logic [7:0] read_byte;
        logic       read_valid;
        logic       want_write_byte;
        logic       done_res;
        logic [1:0] status;
        logic [2:0] card_type;
    } t_out_item;

    typedef struct packed {
        logic [15:0] sd2_ready_retries;
        logic [15:0] legacy_ready_retries;
        logic [7:0]  response_polls;
        logic [15:0] token_wait_limit;
        logic [7:0]  wake_bytes;
    } t_cfg;

    localparam int QUEUE_DEPTH = 2;

endpackage
`default_nettype wire

// File: design/sdspi_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// SD SPI front end
// Accepts requests and configuration writes, holds the register file and
// passes requests through a two-entry queue to the protocol engine.
// ---------------------------------------------------------------------------
module sdspi_front (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_in_valid,
    output logic                    o_in_ready,
    input  sdspi_pkg::t_in_item     i_in_data,
    input  wire                     i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire  [2:0]              i_cfg_index,
    input  wire  [15:0]             i_cfg_data,
    output sdspi_pkg::t_cfg         o_cfg,
    output logic                    o_q_valid,
    input  wire                     i_q_ready,
    output sdspi_pkg::t_in_item     o_q_data
);
    import sdspi_pkg::*;

    t_in_item   r_mem [QUEUE_DEPTH];
    logic       r_wptr, r_rptr;
    logic [1:0] r_count;
    t_cfg       r_cfg;
    logic       w_push, w_pop;

    assign o_in_ready  = (r_count != 2'(QUEUE_DEPTH));
    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;
    assign o_q_valid   = (r_count != 2'd0);
    assign o_q_data    = r_mem[r_rptr];
    assign w_push      = i_in_valid && o_in_ready;
    assign w_pop       = o_q_valid && i_q_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (w_push) r_wptr <= ~r_wptr;
            if (w_pop)  r_rptr <= ~r_rptr;
            r_count <= r_count + 2'(w_push) - 2'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sd2_ready_retries    <= 16'd12000;
            r_cfg.legacy_ready_retries <= 16'd25000;
            r_cfg.response_polls       <= 8'd10;
            r_cfg.token_wait_limit     <= 16'd65535;
            r_cfg.wake_bytes           <= 8'd10;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_SD2_RETRIES: r_cfg.sd2_ready_retries    <= i_cfg_data;
                CFG_LEG_RETRIES: r_cfg.legacy_ready_retries <= i_cfg_data;
                CFG_RESP_POLLS:  r_cfg.response_polls       <= i_cfg_data[7:0];
                CFG_TOKEN_WAIT:  r_cfg.token_wait_limit     <= i_cfg_data;
                CFG_WAKE_BYTES:  r_cfg.wake_bytes           <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 2'(QUEUE_DEPTH)) else $error("queue count overflow");
    a_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'(QUEUE_DEPTH)) |-> !w_push) else $error("push into full queue");
    a_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'd0) |-> !w_pop) else $error("pop from empty queue");
`endif

endmodule
`default_nettype wire

// File: design/sdspi_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// SD SPI protocol engine
// Takes one request per cycle from the queue while the skid is empty and
// computes the result: command framer, response polling and the init,
// read and write sequences, into an output register with a skid stage.
// ---------------------------------------------------------------------------
module sdspi_engine (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  sdspi_pkg::t_cfg         i_cfg,
    input  wire                     i_q_valid,
    output logic                    o_q_ready,
    input  sdspi_pkg::t_in_item     i_q_data,
    output logic                    o_out_valid,
    input  wire                     i_out_ready,
    output sdspi_pkg::t_out_item    o_out_data
);
    import sdspi_pkg::*;

    t_phase      r_phase, n_phase;
    logic [15:0] r_bc, n_bc, r_retry, n_retry;
    logic [7:0]  r_poll, n_poll;
    logic [31:0] r_arg, n_arg, r_ocr, n_ocr;
    logic [7:0]  r_code, n_code, r_lop, n_lop;
    logic        r_app, n_app, r_cbusy, n_cbusy, r_cs, n_cs;
    logic [2:0]  r_kind, n_kind;
    logic [2:0]  r_fpos, n_fpos;
    logic        r_fdone, n_fdone;  // frame sent, polling
    t_out_item   w_res;

    // output register plus skid
    logic        r_ov, r_sv;
    t_out_item   r_od, r_sd;
    logic        w_take;

    assign o_q_ready   = !r_sv;
    assign w_take      = i_q_valid && o_q_ready;
    assign o_out_valid = r_ov;
    assign o_out_data  = r_od;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else begin
            if (r_ov && !i_out_ready) begin
                if (w_take) begin
                    r_sv <= 1'b1;
                end
            end else begin
                r_ov <= r_sv || w_take;
                r_sv <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!(r_ov && !i_out_ready)) begin
            r_od <= r_sv ? r_sd : w_res;
        end
        if (w_take && r_ov && !i_out_ready) begin
            r_sd <= w_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_bc    <= '0;
            r_retry <= '0;
            r_poll  <= '0;
            r_arg   <= '0;
            r_code  <= '0;
            r_app   <= 1'b0;
            r_ocr   <= '0;
            r_kind  <= '0;
            r_cbusy <= 1'b0;
            r_cs    <= 1'b0;
            r_fpos  <= '0;
            r_fdone <= 1'b0;
            r_lop   <= '0;
        end else if (w_take) begin
            r_phase <= n_phase;
            r_bc    <= n_bc;
            r_retry <= n_retry;
            r_poll  <= n_poll;
            r_arg   <= n_arg;
            r_code  <= n_code;
            r_app   <= n_app;
            r_ocr   <= n_ocr;
            r_kind  <= n_kind;
            r_cbusy <= n_cbusy;
            r_cs    <= n_cs;
            r_fpos  <= n_fpos;
            r_fdone <= n_fdone;
            r_lop   <= n_lop;
        end
    end

    // Frame byte for position 1..7 given the current command.
    function automatic logic [7:0] f_frame(input logic [2:0] pos, input logic app,
                                           input logic [7:0] code, input logic [31:0] arg);
        logic [7:0]  op;
        logic [31:0] a;
        op = app ? OP_APP : {1'b0, code[6:0]};
        a  = app ? 32'd0 : arg;
        unique case (pos)
            3'd1: f_frame = 8'hFF;
            3'd2: f_frame = op;
            3'd3: f_frame = a[31:24];
            3'd4: f_frame = a[23:16];
            3'd5: f_frame = a[15:8];
            3'd6: f_frame = a[7:0];
            default: f_frame = (op == OP_IDLE) ? 8'h95 :
                               (op == OP_IF_COND) ? 8'h87 : 8'h01;
        endcase
    endfunction

    always_comb begin
        logic [7:0]  rx, wb, rsp, npoll;
        logic        resp_in;
        logic [31:0] ocr_sh;
        logic [15:0] bc1, rt1;
        // helper macros expressed as inline assignments below
        rx = i_q_data.rx_byte;
        wb = i_q_data.write_byte;
        n_phase = r_phase; n_bc = r_bc; n_retry = r_retry; n_poll = r_poll;
        n_arg = r_arg; n_code = r_code; n_app = r_app; n_ocr = r_ocr;
        n_kind = r_kind; n_cbusy = r_cbusy; n_cs = r_cs; n_fpos = r_fpos;
        n_fdone = r_fdone; n_lop = r_lop;
        w_res = '0;
        w_res.tx_byte = 8'hFF;
        resp_in = 1'b0;
        rsp = rx;
        npoll = r_poll - 8'd1;
        ocr_sh = {r_ocr[23:0], rx};
        bc1 = r_bc + 16'd1;
        rt1 = r_retry + 16'd1;

        if (i_q_data.action != ACT_BYTE) begin
            n_cbusy = 1'b0; n_app = 1'b0; n_bc = '0;
        end
        unique case (t_action'(i_q_data.action))
            ACT_INIT: begin
                n_kind = CK_UNKNOWN;
                if (i_cfg.wake_bytes != 8'd0) begin
                    n_phase = PH_WAKE;
                    w_res.exchange = 1'b1; n_cs = 1'b0; w_res.slow_clock = 1'b1;
                end else begin
                    n_phase = PH_CMD0;
                    n_code = OP_IDLE; n_arg = '0; n_app = 1'b0;
                    n_fpos = '0; n_fdone = 1'b0; n_cbusy = 1'b1;
                    w_res.exchange = 1'b1; n_cs = 1'b0;
                end
            end
            ACT_READ: begin
                n_phase = PH_RD_CMD;
                n_code = OP_READ; n_arg = i_q_data.block_address; n_app = 1'b0;
                n_fpos = '0; n_fdone = 1'b0; n_cbusy = 1'b1;
                w_res.exchange = 1'b1; n_cs = 1'b0;
            end
            ACT_WRITE: begin
                n_phase = PH_WR_CMD;
                n_code = OP_WRITE; n_arg = i_q_data.block_address; n_app = 1'b0;
                n_fpos = '0; n_fdone = 1'b0; n_cbusy = 1'b1;
                w_res.exchange = 1'b1; n_cs = 1'b0;
            end
            default: begin
                if (r_phase != PH_IDLE) begin
                    if (r_cbusy) begin
                        // command framer and response poll
                        if (!r_fdone && r_fpos != 3'd7) begin
                            n_fpos = r_fpos + 3'd1;
                            w_res.exchange = 1'b1; n_cs = 1'b1;
                            w_res.tx_byte = f_frame(n_fpos, r_app, r_code, r_arg);
                        end else if (!r_fdone) begin
                            n_fdone = 1'b1;
                            n_poll = (i_cfg.response_polls != 8'd0) ?
                                     i_cfg.response_polls : 8'd1;
                            w_res.exchange = 1'b1; n_cs = 1'b1;
                        end else begin
                            n_poll = npoll;
                            if (rx[7] && npoll != 8'd0) begin
                                w_res.exchange = 1'b1; n_cs = 1'b1;
                            end else if (r_app && rx <= 8'd1) begin
                                n_app = 1'b0; n_fpos = '0; n_fdone = 1'b0;
                                w_res.exchange = 1'b1; n_cs = 1'b0;
                            end else begin
                                n_app = 1'b0;
                                n_cbusy = 1'b0;
                                resp_in = 1'b1;
                            end
                        end
                    end else begin
                        priority case (r_phase)
                            PH_WAKE: begin
                                n_bc = bc1;
                                if (bc1 < {8'd0, i_cfg.wake_bytes}) begin
                                    w_res.exchange = 1'b1; n_cs = 1'b0;
                                    w_res.slow_clock = 1'b1;
                                end else begin
                                    n_phase = PH_CMD0;
                                    n_code = OP_IDLE; n_arg = '0; n_app = 1'b0;
                                    n_fpos = '0; n_fdone = 1'b0; n_cbusy = 1'b1;
                                    w_res.exchange = 1'b1; n_cs = 1'b0;
                                end
                            end
                            PH_GAP0: begin
                                n_phase = PH_CMD8;
                                n_code = OP_IF_COND; n_arg = 32'h1AA; n_app = 1'b0;
                                n_fpos = '0; n_fdone = 1'b0; n_cbusy = 1'b1;
                                w_res.exchange = 1'b1; n_cs = 1'b0;
                            end
                            PH_OCR8, PH_OCR58: begin
                                n_ocr = ocr_sh;
                                n_bc = bc1;
                                if (bc1 < 16'd4) begin
                                    w_res.exchange = 1'b1; n_cs = 1'b1;
                                end else if (r_phase == PH_OCR58) begin
                                    n_kind = ocr_sh[30] ? CK_SD2_BLK : CK_SD2_BYTE;
                                    w_res.done_res = 1'b1; n_phase = PH_IDLE;
                                end else if (ocr_sh[15:0] == 16'h01AA) begin
                                    n_retry = i_cfg.sd2_ready_retries;
                                    if (i_cfg.sd2_ready_retries != 16'd0) begin
                                        n_phase = PH_V2LOOP;
                                        n_code = OP_APP_OP_COND; n_arg = 32'h4000_0000;
                                        n_app = 1'b1; n_fpos = '0; n_fdone = 1'b0;
                                        n_cbusy = 1'b1;
                                        w_res.exchange = 1'b1; n_cs = 1'b0;
                                    end else begin
                                        w_res.done_res = 1'b1; n_phase = PH_IDLE;
                                    end
                                end else begin
                                    w_res.done_res = 1'b1; n_phase = PH_IDLE;
                                end
                            end
                            PH_RD_GAP: begin
                                n_retry = '0; n_phase = PH_RD_TOKEN;
                                w_res.exchange = 1'b1; n_cs = 1'b1;
                            end
                            PH_RD_TOKEN: begin
                                n_retry = rt1;
                                if (rt1 >= i_cfg.token_wait_limit) begin
                                    w_res.done_res = 1'b1; w_res.status = ST_RD_FAIL;
                                    n_phase = PH_IDLE;
                                end else begin
                                    if (rx == 8'hFE) begin
                                        n_bc = '0; n_phase = PH_RD_DATA;
                                    end
                                    w_res.exchange = 1'b1; n_cs = 1'b1;
                                end
                            end
                            PH_RD_DATA: begin
                                w_res.read_byte = rx; w_res.read_valid = 1'b1;
                                n_bc = bc1;
                                if (bc1 >= 16'(BLOCK_BYTES)) begin
                                    n_bc = '0; n_phase = PH_RD_TAIL;
                                end
                                w_res.exchange = 1'b1; n_cs = 1'b1;
                            end
                            PH_RD_TAIL: begin
                                n_bc = bc1;
                                if (bc1 < 16'd2) begin
                                    w_res.exchange = 1'b1; n_cs = 1'b1;
                                end else begin
                                    w_res.done_res = 1'b1; n_phase = PH_IDLE;
                                end
                            end
                            PH_WR_GAP: begin
                                n_phase = PH_WR_TOKEN;
                                w_res.tx_byte = 8'hFE;
                                w_res.exchange = 1'b1; n_cs = 1'b1;
                                w_res.want_write_byte = 1'b1;
                            end
                            PH_WR_TOKEN, PH_WR_DATA: begin
                                logic [15:0] b0, b1;
                                b0 = (r_phase == PH_WR_TOKEN) ? 16'd0 : r_bc;
                                b1 = b0 + 16'd1;
                                n_phase = PH_WR_DATA;
                                if (b0 < 16'(BLOCK_BYTES)) begin
                                    w_res.tx_byte = wb;
                                    n_bc = b1;
                                    w_res.want_write_byte = (b1 < 16'(BLOCK_BYTES));
                                end else begin
                                    n_bc = '0; n_phase = PH_WR_TAIL;
                                end
                                w_res.exchange = 1'b1; n_cs = 1'b1;
                            end
                            PH_WR_TAIL: begin
                                n_bc = bc1;
                                if (bc1 >= 16'd2) n_phase = PH_WR_RESP;
                                w_res.exchange = 1'b1; n_cs = 1'b1;
                            end
                            PH_WR_RESP: begin
                                if (rx[4:0] != 5'h05) begin
                                    w_res.done_res = 1'b1; w_res.status = ST_WR_FAIL;
                                    n_phase = PH_IDLE;
                                end else begin
                                    n_retry = '0; n_phase = PH_WR_BUSY;
                                    w_res.exchange = 1'b1; n_cs = 1'b1;
                                end
                            end
                            PH_WR_BUSY: begin
                                n_retry = rt1;
                                if (rt1 >= i_cfg.token_wait_limit) begin
                                    w_res.done_res = 1'b1; w_res.status = ST_WR_FAIL;
                                    n_phase = PH_IDLE;
                                end else if (rx == 8'hFF) begin
                                    w_res.done_res = 1'b1; n_phase = PH_IDLE;
                                end else begin
                                    w_res.exchange = 1'b1; n_cs = 1'b1;
                                end
                            end
                            default: begin
                                w_res.done_res = 1'b1; n_phase = PH_IDLE;
                            end
                        endcase
                    end
                end
            end
        endcase

        // Response handling for command phases.
        if (resp_in) begin
            priority case (r_phase)
                PH_CMD0: begin
                    if (rsp == 8'd1) begin
                        n_phase = PH_GAP0; w_res.exchange = 1'b1; n_cs = 1'b1;
                    end else begin
                        w_res.done_res = 1'b1; w_res.status = ST_NO_IDLE;
                        n_phase = PH_IDLE;
                    end
                end
                PH_CMD8: begin
                    if (rsp == 8'd1) begin
                        n_phase = PH_OCR8; n_bc = '0; n_ocr = '0;
                        w_res.exchange = 1'b1; n_cs = 1'b1;
                    end else begin
                        n_phase = PH_PROBE;
                        n_code = OP_APP_OP_COND; n_arg = '0; n_app = 1'b1;
                        n_fpos = '0; n_fdone = 1'b0; n_cbusy = 1'b1;
                        w_res.exchange = 1'b1; n_cs = 1'b0;
                    end
                end
                PH_V2LOOP: begin
                    if (rsp == 8'd0) begin
                        n_phase = PH_CMD58;
                        n_code = OP_READ_OCR; n_arg = '0; n_app = 1'b0;
                        n_fpos = '0; n_fdone = 1'b0; n_cbusy = 1'b1;
                        w_res.exchange = 1'b1; n_cs = 1'b0;
                    end else begin
                        n_retry = r_retry - 16'd1;
                        if (n_retry != 16'd0) begin
                            n_code = OP_APP_OP_COND; n_arg = 32'h4000_0000;
                            n_app = 1'b1; n_fpos = '0; n_fdone = 1'b0; n_cbusy = 1'b1;
                            w_res.exchange = 1'b1; n_cs = 1'b0;
                        end else begin
                            w_res.done_res = 1'b1; n_phase = PH_IDLE;
                        end
                    end
                end
                PH_CMD58: begin
                    if (rsp == 8'd0) begin
                        n_phase = PH_OCR58; n_bc = '0; n_ocr = '0;
                        w_res.exchange = 1'b1; n_cs = 1'b1;
                    end else begin
                        w_res.done_res = 1'b1; n_phase = PH_IDLE;
                    end
                end
                PH_PROBE, PH_LEGLOOP: begin
                    logic [7:0]  lop;
                    logic [15:0] rt;
                    if (r_phase == PH_PROBE) begin
                        n_kind = (rsp <= 8'd1) ? CK_SD1 : CK_MMC;
                        lop = (rsp <= 8'd1) ? OP_APP_OP_COND : OP_SEND_OP;
                        rt = i_cfg.legacy_ready_retries;
                    end else begin
                        lop = r_lop;
                        rt = r_retry - 16'd1;
                    end
                    n_lop = lop;
                    n_retry = rt;
                    if (r_phase == PH_LEGLOOP && rsp == 8'd0) begin
                        n_retry = r_retry;
                        n_phase = PH_CMD16;
                        n_code = OP_SET_LEN; n_arg = 32'(BLOCK_BYTES); n_app = 1'b0;
                        n_fpos = '0; n_fdone = 1'b0; n_cbusy = 1'b1;
                        w_res.exchange = 1'b1; n_cs = 1'b0;
                    end else if (rt != 16'd0) begin
                        n_phase = PH_LEGLOOP;
                        n_code = lop; n_arg = '0; n_app = lop[7];
                        n_fpos = '0; n_fdone = 1'b0; n_cbusy = 1'b1;
                        w_res.exchange = 1'b1; n_cs = 1'b0;
                    end else begin
                        n_kind = CK_UNKNOWN;
                        w_res.done_res = 1'b1; n_phase = PH_IDLE;
                    end
                end
                PH_CMD16: begin
                    if (rsp != 8'd0) n_kind = CK_UNKNOWN;
                    w_res.done_res = 1'b1; n_phase = PH_IDLE;
                end
                PH_RD_CMD: begin
                    if (rsp != 8'd0) begin
                        w_res.done_res = 1'b1; w_res.status = ST_RD_FAIL;
                        n_phase = PH_IDLE;
                    end else begin
                        n_phase = PH_RD_GAP; w_res.exchange = 1'b1; n_cs = 1'b1;
                    end
                end
                PH_WR_CMD: begin
                    if (rsp != 8'd0) begin
                        w_res.done_res = 1'b1; w_res.status = ST_WR_FAIL;
                        n_phase = PH_IDLE;
                    end else begin
                        n_phase = PH_WR_GAP; w_res.exchange = 1'b1; n_cs = 1'b1;
                    end
                end
                default: begin
                    w_res.done_res = 1'b1; n_phase = PH_IDLE;
                end
            endcase
        end
        if (w_res.done_res) n_cbusy = 1'b0;
        w_res.select_card = n_cs;
        w_res.card_type = n_kind;
    end

`ifndef SYNTHESIS
    a_skid_only_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sv |-> r_ov) else $error("skid holds data with empty output register");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !i_out_ready) |=> $stable(r_od)) else $error("stalled result changed");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && w_res.done_res) |=> (r_phase == PH_IDLE))
        else $error("done without return to idle");
    a_slow_deselect: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && w_res.slow_clock) |-> !w_res.select_card)
        else $error("slow clock with card selected");
`endif

endmodule
`default_nettype wire

// File: design/sd_card_spi_host_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// SD card SPI host engine
// One request per byte-exchange step: start init, start read, start write,
// or report the byte just exchanged. Each request yields one result.
// ---------------------------------------------------------------------------
// Requests enter a two-entry queue and the protocol engine takes one per
// clock, so the block sustains one request per cycle while the result port
// accepts; each result is registered, and a skid stage lets the engine
// finish one more request while the result port is stalled. A request
// goes through the queue, then the output register. Configuration writes
// are taken at any time and should only be issued while no operation runs.
module sd_card_spi_host_engine (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_in_valid,
    output logic                    o_in_ready,
    input  sdspi_pkg::t_in_item     i_in_data,
    output logic                    o_out_valid,
    input  wire                     i_out_ready,
    output sdspi_pkg::t_out_item    o_out_data,
    input  wire                     i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire  [2:0]              i_cfg_index,
    input  wire  [15:0]             i_cfg_data
);
    import sdspi_pkg::*;

    t_cfg     w_cfg;
    logic     w_q_valid, w_q_ready;
    t_in_item w_q_data;

    sdspi_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg),
        .o_q_valid   (w_q_valid),
        .i_q_ready   (w_q_ready),
        .o_q_data    (w_q_data)
    );

    sdspi_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_q_valid   (w_q_valid),
        .o_q_ready   (w_q_ready),
        .i_q_data    (w_q_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule
`default_nettype wire
